### design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge, with reset taken into account.
`define ASSERT_CLK(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checked at the clock edge after each edge at which reset is seen asserted.
`define ASSERT_AFTER_RST(label, clk, rst_n, cons, msg) \
    label: assert property (@(posedge clk) !rst_n |=> (cons)) else $error(msg);

`endif

### design/cmnt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cmnt_pkg;
    localparam int FACE_SIZE_DEF = 32;
    localparam int COORD_W       = 18;
    localparam int SQ_W          = 22;
    localparam int INV_W         = 17;
    localparam int ACC_W         = 53;
    localparam int MS_W          = 40;
    localparam int N_ITER        = 17;
    localparam int ONE_Q16       = 65536;

    localparam logic [2:0] FACE_PX = 3'd0;
    localparam logic [2:0] FACE_NX = 3'd1;
    localparam logic [2:0] FACE_PY = 3'd2;
    localparam logic [2:0] FACE_NY = 3'd3;
    localparam logic [2:0] FACE_PZ = 3'd4;
    localparam logic [2:0] FACE_NZ = 3'd5;

    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } t_vec;
endpackage
`default_nettype wire

### design/cmnt_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface cmnt_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] face;
    logic [4:0] col;
    logic [4:0] row;
    modport source (output valid, face, col, row, input ready);
    modport sink   (input valid, face, col, row, output ready);
endinterface

interface cmnt_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    modport source (output valid, red, green, blue, alpha, input ready);
    modport sink   (input valid, red, green, blue, alpha, output ready);
endinterface
`default_nettype wire

### design/cube_map_normal_texel.sv
`timescale 1ns / 1ps
`default_nettype none
// Normalization cube map texel generator. Each request names a face (0 +X .. 5 -Z)
// and a column and row; the response carries the unit direction of that texel
// coded per component as floor(128 + 127*v), with alpha fixed at 255. Faces six and
// seven give 128,128,128. One request is taken every clock unless the response stalls;
// it passes the face, squared-length, 17-stage bit-by-bit inverse square root, product
// and output stages, and a stalled response holds the whole pipeline.
`include "assert_macros.svh"
module cube_map_normal_texel
    import cmnt_pkg::*;
#(
    parameter int FACE_SIZE = FACE_SIZE_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    cmnt_req_if.sink   i_req,
    cmnt_rsp_if.source o_rsp
);
    localparam int LOG_SIZE = $clog2(FACE_SIZE);
    localparam int SHIFT    = 16 - LOG_SIZE;
    localparam logic [10:0] POS_MASK = 11'(FACE_SIZE - 1);

    logic w_en;
    assign w_en = !o_rsp.valid || o_rsp.ready;
    assign i_req.ready = w_en;

    function automatic logic signed [COORD_W-1:0] coord(input logic [4:0] pos);
        logic [10:0] p;
        logic [18:0] t;
        p = {6'd0, pos} & POS_MASK;
        t = {7'd0, p, 1'b1} << SHIFT;
        return COORD_W'($signed(t) - 19'sd65536);
    endfunction

    function automatic logic [7:0] to_byte(input logic signed [35:0] prod);
        logic signed [44:0] num;
        num = (45'sd128 <<< 32) + (45'(prod) <<< 7) - 45'(prod);
        if (num < 0) begin
            return 8'd0;
        end else if (num[44:32] > 13'd255) begin
            return 8'd255;
        end else begin
            return num[39:32];
        end
    endfunction

    // Stage A: face vector.
    logic signed [COORD_W-1:0] w_sc, w_tc;
    localparam logic signed [COORD_W-1:0] ONE = COORD_W'(ONE_Q16);
    t_vec n_a_vec, r_a_vec;
    logic r_a_vld;

    assign w_sc = coord(i_req.col);
    assign w_tc = coord(i_req.row);

    always_comb begin
        n_a_vec = '0;
        unique case (i_req.face)
            FACE_PX: n_a_vec = '{x: ONE,  y: -w_tc, z: -w_sc};
            FACE_NX: n_a_vec = '{x: -ONE, y: -w_tc, z: w_sc};
            FACE_PY: n_a_vec = '{x: w_sc, y: ONE,   z: w_tc};
            FACE_NY: n_a_vec = '{x: w_sc, y: -ONE,  z: -w_tc};
            FACE_PZ: n_a_vec = '{x: w_sc, y: -w_tc, z: ONE};
            FACE_NZ: n_a_vec = '{x: -w_sc, y: -w_tc, z: -ONE};
            default: n_a_vec = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (w_en) begin
            r_a_vld <= i_req.valid;
        end
        if (w_en) begin
            r_a_vec <= n_a_vec;
        end
    end

    // Stage B (index 0 of the arrays): squared length, then one result bit a stage.
    logic [ACC_W-1:0] r_p [0:N_ITER];
    logic [MS_W-1:0]  r_t [0:N_ITER];
    logic [INV_W-1:0] r_m [0:N_ITER];
    logic [SQ_W-1:0]  r_s [0:N_ITER];
    t_vec             r_v [0:N_ITER];
    logic             r_vld [0:N_ITER];
    logic signed [37:0] n_sum;

    assign n_sum = 38'(r_a_vec.x * r_a_vec.x) + 38'(r_a_vec.y * r_a_vec.y)
                 + 38'(r_a_vec.z * r_a_vec.z);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (w_en) begin
            r_vld[0] <= r_a_vld;
        end
        if (w_en) begin
            r_p[0] <= '0;
            r_t[0] <= '0;
            r_m[0] <= '0;
            r_s[0] <= n_sum[33:12];
            r_v[0] <= r_a_vec;
        end
    end

    // Keeps P = m*m*s and T = m*s so that each trial bit costs only adds.
    for (genvar k = 0; k < N_ITER; k++) begin : g_iter
        localparam int B = N_ITER - 1 - k;
        logic [57:0]      w_cand;
        logic             w_take;
        logic [ACC_W-1:0] n_p;
        logic [MS_W-1:0]  n_t;
        logic [INV_W-1:0] n_m;

        always_comb begin
            w_cand = 58'(r_p[k]) + (58'(r_t[k]) << (B + 1)) + (58'(r_s[k]) << (2 * B));
            w_take = w_cand <= (58'd1 << 52);
            n_p    = w_take ? w_cand[ACC_W-1:0] : r_p[k];
            n_t    = w_take ? r_t[k] + (MS_W'(r_s[k]) << B) : r_t[k];
            n_m    = w_take ? (r_m[k] | (INV_W'(1) << B)) : r_m[k];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (w_en) begin
                r_vld[k+1] <= r_vld[k];
            end
            if (w_en) begin
                r_p[k+1] <= n_p;
                r_t[k+1] <= n_t;
                r_m[k+1] <= n_m;
                r_s[k+1] <= r_s[k];
                r_v[k+1] <= r_v[k];
            end
        end
    end

    // Stage C: component times inverse length.
    logic signed [35:0] r_px, r_py, r_pz;
    logic signed [INV_W:0] w_m;
    logic r_c_vld;
    assign w_m = $signed({1'b0, r_m[N_ITER]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (w_en) begin
            r_c_vld <= r_vld[N_ITER];
        end
        if (w_en) begin
            r_px <= 36'(r_v[N_ITER].x * w_m);
            r_py <= 36'(r_v[N_ITER].y * w_m);
            r_pz <= 36'(r_v[N_ITER].z * w_m);
        end
    end

    // Stage D: output register.
    logic       r_o_vld;
    logic [7:0] r_red, r_green, r_blue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (w_en) begin
            r_o_vld <= r_c_vld;
        end
        if (w_en) begin
            r_red   <= to_byte(r_px);
            r_green <= to_byte(r_py);
            r_blue  <= to_byte(r_pz);
        end
    end

    assign o_rsp.valid = r_o_vld;
    assign o_rsp.red   = r_red;
    assign o_rsp.green = r_green;
    assign o_rsp.blue  = r_blue;
    assign o_rsp.alpha = ALPHA_OPAQUE;

    `ASSERT_CLK(a_stall_blocks, i_clk, i_rst_n, o_rsp.valid && !o_rsp.ready, !i_req.ready, "request taken while the response is stalled")
    `ASSERT_CLK(a_stall_holds_pipe, i_clk, i_rst_n, !i_req.ready, ##1 $stable(r_c_vld) && $stable(r_vld[0]), "pipeline moved during a stall")
    `ASSERT_AFTER_RST(a_rst_empty, i_clk, i_rst_n, !o_rsp.valid && !r_c_vld, "response valid right after reset")
endmodule
`default_nettype wire

### test/tb.sv
`timescale 1ns / 1ps
module tb;
    import cmnt_pkg::*;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_texel;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    cmnt_req_if req_if ();
    cmnt_rsp_if rsp_if ();

    cube_map_normal_texel dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if.sink),
        .o_rsp  (rsp_if.source)
    );

    always #5 i_clk = ~i_clk;

    t_texel texel_q[$];
    int     n_sent = 0;
    int     n_got = 0;
    int     n_err = 0;
    int     n_bad_face = 0;
    int     stall_len = 0;
    int     stall_mode = 0;

    // Face coordinate in Q2.16 for a column or row of a 32-texel face.
    function automatic longint face_coord(logic [4:0] pos);
        longint p;
        p = pos;
        return ((2 * p + 1) << 16) / 32 - ONE_Q16;
    endfunction

    function automatic logic [7:0] comp_byte(longint comp, longint m);
        longint num;
        longint b;
        num = (longint'(128) <<< 32) + 127 * comp * m;
        if (num < 0)
            num = 0;
        b = num >>> 32;
        return (b > 255) ? 8'd255 : b[7:0];
    endfunction

    function automatic t_texel normal_texel(logic [2:0] face, logic [4:0] col,
                                            logic [4:0] row);
        t_texel t;
        longint sc, tc, vx, vy, vz;
        longint unsigned s, m, cand;
        sc = face_coord(col);
        tc = face_coord(row);
        t.alpha = ALPHA_OPAQUE;
        case (face)
            FACE_PX: begin vx = ONE_Q16;  vy = -tc;      vz = -sc;      end
            FACE_NX: begin vx = -ONE_Q16; vy = -tc;      vz = sc;       end
            FACE_PY: begin vx = sc;       vy = ONE_Q16;  vz = tc;       end
            FACE_NY: begin vx = sc;       vy = -ONE_Q16; vz = -tc;      end
            FACE_PZ: begin vx = sc;       vy = -tc;      vz = ONE_Q16;  end
            FACE_NZ: begin vx = -sc;      vy = -tc;      vz = -ONE_Q16; end
            default: begin
                t.red = 8'd128;
                t.green = 8'd128;
                t.blue = 8'd128;
                return t;
            end
        endcase
        s = longint'(vx * vx + vy * vy + vz * vz) >> 12;
        m = 0;
        for (int bit_i = 16; bit_i >= 0; bit_i--) begin
            cand = m | (64'd1 << bit_i);
            if (cand * cand * s <= (64'd1 << 52))
                m = cand;
        end
        t.red = comp_byte(vx, m);
        t.green = comp_byte(vy, m);
        t.blue = comp_byte(vz, m);
        return t;
    endfunction

    task automatic send_texel(logic [2:0] face, logic [4:0] col, logic [4:0] row);
        req_if.valid <= 1'b1;
        req_if.face <= face;
        req_if.col <= col;
        req_if.row <= row;
        @(posedge i_clk);
        while (!req_if.ready)
            @(posedge i_clk);
        texel_q.push_back(normal_texel(face, col, row));
        n_sent++;
        if (face > FACE_NZ)
            n_bad_face++;
    endtask

    task automatic idle_sender(int cycles);
        req_if.valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic test_corners();
        for (int f = 0; f < 8; f++) begin
            send_texel(f[2:0], 5'd0, 5'd0);
            send_texel(f[2:0], 5'd31, 5'd31);
        end
        send_texel(FACE_PX, 5'd0, 5'd31);
        send_texel(FACE_NZ, 5'd31, 5'd0);
        send_texel(FACE_PY, 5'd15, 5'd16);
        send_texel(FACE_NY, 5'd16, 5'd15);
        send_texel(FACE_PZ, 5'd15, 5'd15);
        send_texel(FACE_NX, 5'd16, 5'd16);
        idle_sender(1);
    endtask

    task automatic test_full_sweep();
        for (int f = 0; f < 6; f++)
            for (int r = 0; r < 32; r += 3)
                for (int c = 0; c < 32; c += 5)
                    send_texel(f[2:0], c[4:0], r[4:0]);
        idle_sender(1);
    endtask

    task automatic test_random_bursts(int count);
        int burst;
        int sent;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 40);
            for (int i = 0; i < burst && sent < count; i++) begin
                if ($urandom_range(0, 15) == 0)
                    send_texel(3'($urandom_range(6, 7)), 5'($urandom), 5'($urandom));
                else
                    send_texel(3'($urandom_range(0, 5)), 5'($urandom), 5'($urandom));
                sent++;
            end
            if ($urandom_range(0, 3) != 0)
                idle_sender($urandom_range(1, 12));
        end
        idle_sender(1);
    endtask

    // Receiver alternates between always-ready stretches and random stalls.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (stall_len == 0) begin
                stall_len = $urandom_range(20, 120);
                stall_mode = $urandom_range(0, 2);
            end else begin
                stall_len--;
            end
            case (stall_mode)
                0: rsp_if.ready <= 1'b1;
                1: rsp_if.ready <= ($urandom_range(0, 3) != 0);
                default: rsp_if.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_texel exp_t;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            n_got++;
            if (texel_q.size() == 0) begin
                n_err++;
                if (n_err <= 10)
                    $display("Response with no request pending: %0d %0d %0d %0d",
                             rsp_if.red, rsp_if.green, rsp_if.blue, rsp_if.alpha);
            end else begin
                exp_t = texel_q.pop_front();
                if (rsp_if.red !== exp_t.red || rsp_if.green !== exp_t.green ||
                    rsp_if.blue !== exp_t.blue || rsp_if.alpha !== exp_t.alpha) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("Texel mismatch: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                                 exp_t.red, exp_t.green, exp_t.blue, exp_t.alpha,
                                 rsp_if.red, rsp_if.green, rsp_if.blue, rsp_if.alpha);
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("Timed out with %0d responses outstanding", texel_q.size());
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int wait_cycles;
        req_if.valid = 1'b0;
        req_if.face = '0;
        req_if.col = '0;
        req_if.row = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_corners();
        test_full_sweep();
        test_random_bursts(1400);
        wait_cycles = 0;
        while (texel_q.size() != 0 && wait_cycles < 100000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (40) @(posedge i_clk);
        if (texel_q.size() != 0) begin
            n_err++;
            $display("%0d responses never arrived", texel_q.size());
        end
        $display("Sent %0d texel requests (%0d on faces six and seven), checked %0d responses.",
                 n_sent, n_bad_face, n_got);
        if (n_err == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

### cube_map_normal_texel.f
+incdir+design
design/cmnt_pkg.sv
design/cmnt_if.sv
design/cube_map_normal_texel.sv
test/tb.sv
